### design/bole_pkg.sv
// Shared constants, operation and status codes, and the control structs
// of the bounded ordered list engine. No dependencies.
package bole_pkg;

    // Storage geometry.
    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 32;

    // Fixed field widths of the request and response channels.
    localparam int FUNC_W = 3;
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 2;
    localparam int LEN_W  = 6;

    // Derived widths: cell index, entry count, and a width wide enough to
    // compare a request position against the entry count.
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT = 3'd0,
        FN_PUSH_BACK  = 3'd1,
        FN_FIND       = 3'd2,
        FN_DELETE     = 3'd3,
        FN_READ       = 3'd4
    } func_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;   // a request transfer happens this cycle
        logic scan;   // the find scan is running
    } bole_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_find;    // the offered request is a find
        logic scan_done;  // the scan ends this cycle
    } bole_sts_t;

endpackage

### design/bole_req_if.sv
// Request channel of the ordered list engine: valid/ready plus payload.
// Depends on bole_pkg.
interface bole_req_if import bole_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [DATA_W-1:0] item_value;
    logic [POS_W-1:0]         position;

    modport source (output valid, output func, output item_value, output position,
                    input ready);
    modport sink   (input valid, input func, input item_value, input position,
                    output ready);
endinterface

### design/bole_rsp_if.sv
// Response channel of the ordered list engine: valid/ready plus payload.
// Depends on bole_pkg.
interface bole_rsp_if import bole_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [POS_W-1:0]         found_position;
    logic signed [DATA_W-1:0] read_value;
    logic [LEN_W-1:0]         length;

    modport source (output valid, output status, output found_position,
                    output read_value, output length, input ready);
    modport sink   (input valid, input status, input found_position,
                    input read_value, input length, output ready);
endinterface

### design/bounded_ordered_list_engine_unit.sv
// Bounded ordered list engine: push front/back, find, delete and read on a row of cells.
// Push, delete and read results are registered, ready in the cycle after the request transfer; they run
// back to back at one per cycle while each result is taken at once. A find scans from the front
// to the first match or the end of the list, as the scan reads one cell per cycle.
// Reset: asynchronous, active low; clears the entry count, scan index, controller state and
// response valid, but not the cells. Depends on bole_pkg, both interfaces, bole_ctrl, bole_dpath.
module bounded_ordered_list_engine_unit import bole_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bole_req_if.sink   request,
    bole_rsp_if.source response
);

    // Commands and status between the controller and the datapath.
    bole_cmd_t cmd;
    bole_sts_t sts;

    // The controller owns both handshakes. A request transfer is taken only
    // in its idle state and only when the response register is empty or is
    // emptied by a transfer in the same cycle, so a finished result never
    // blocks the next request for longer than its own transfer.
    bole_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .out_ready (response.ready),
        .sts       (sts),
        .in_ready  (request.ready),
        .out_valid (response.valid),
        .cmd       (cmd)
    );

    // The datapath holds the list as a row of cells. Push front and delete move
    // every affected cell together, each cell taking its neighbour's value;
    // push back writes only the cell at the end; reads use the one read port. A find walks that same read port
    // from the front, one cell per cycle, and stops at the first match or at
    // the end of the list.
    bole_dpath u_dpath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .func           (request.func),
        .item_value     (request.item_value),
        .position       (request.position),
        .status         (response.status),
        .found_position (response.found_position),
        .read_value     (response.read_value),
        .length         (response.length)
    );

`ifndef SYNTHESIS
    // No request transfer may happen while a result waits untaken.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (request.valid && request.ready) |-> (!response.valid || response.ready))
        else $error("request taken while the response register was held");

    // While a find scan runs, no new request is taken.
    a_scan_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan |-> !request.ready)
        else $error("request ready during a find scan");

    // A refused push only happens on a full list.
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && (response.status == ST_FULL))
            |-> (response.length == LEN_W'(CAPACITY)))
        else $error("full status with a list that is not full");

    // Failed finds, deletes and reads return no value.
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (response.valid && ((response.status == ST_RANGE) ||
                            (response.status == ST_NOT_FOUND)))
            |-> (response.read_value == '0))
        else $error("value returned with a failure status");
`endif

endmodule

### design/bole_ctrl.sv
// Controller of the ordered list engine: handshake control and find scan.
// Depends on bole_pkg.
module bole_ctrl import bole_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_ready,
    input  bole_sts_t sts,
    output logic      in_ready,
    output logic      out_valid,
    output bole_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // A new request may enter in the idle state whenever the response register is free or is
    // being emptied in the same cycle.
    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign cmd.exec  = in_valid && in_ready;
    assign cmd.scan  = (state_reg == S_SCAN);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.exec)
                begin
                    if (sts.is_find)
                        state_next = S_SCAN;
                    else
                        out_valid_next = 1'b1;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### design/bole_dpath.sv
// Datapath of the ordered list engine: the row of list cells, the entry
// count, the scan index and the response payload register. Depends on bole_pkg.
module bole_dpath import bole_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  bole_cmd_t                cmd,
    output bole_sts_t                sts,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [DATA_W-1:0] item_value,
    input  logic [POS_W-1:0]         position,
    output logic [STAT_W-1:0]        status,
    output logic [POS_W-1:0]         found_position,
    output logic signed [DATA_W-1:0] read_value,
    output logic [LEN_W-1:0]         length
);

    logic [VALUE_WIDTH-1:0] cells_reg  [CAPACITY];
    logic [VALUE_WIDTH-1:0] cells_next [CAPACITY];
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [POS_W-1:0]       pos_reg;

    logic [STAT_W-1:0]      status_reg, status_next;
    logic [POS_W-1:0]       fpos_reg, fpos_next;
    logic [DATA_W-1:0]      rval_reg, rval_next;
    logic [LEN_W-1:0]       len_reg, len_next;
    logic                   out_load;

    func_t                  op;
    status_t                res_status;
    logic [DATA_W-1:0]      res_rval;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [CMP_W-1:0]       pos_c;
    logic [CMP_W-1:0]       cnt_c;
    logic                   full;
    logic                   in_range;
    logic [IDX_W-1:0]       rd_idx;
    logic [VALUE_WIDTH-1:0] rd_data;
    logic                   scan_end;
    logic                   match;

    assign op       = func_t'(func);
    assign in_val   = VALUE_WIDTH'(item_value);
    assign pos_c    = CMP_W'(position);
    assign cnt_c    = CMP_W'(count_reg);
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign in_range = (pos_c < cnt_c);

    // Single read port: the request position on a transfer, the scan index
    // while a find is running.
    assign rd_idx  = cmd.exec ? IDX_W'(position) : IDX_W'(idx_reg);
    assign rd_data = cells_reg[rd_idx];

    // The length check comes first, since the cell under the index is
    // then beyond the list.
    assign scan_end = (idx_reg == count_reg);
    assign match    = !scan_end && (rd_data == value_reg);

    assign sts.is_find   = (op == FN_FIND);
    assign sts.scan_done = scan_end || match;

    always_comb
    begin
        cells_next = cells_reg;
        count_next = count_reg;
        res_status = ST_OK;
        res_rval   = '0;
        if (cmd.exec)
        begin
            unique case (op)
                FN_PUSH_FRONT:
                begin
                    if (full)
                        res_status = ST_FULL;
                    else
                    begin
                        cells_next[0] = in_val;
                        for (int i = 1; i < CAPACITY; i++)
                            cells_next[i] = cells_reg[i-1];
                        count_next = count_reg + 1'b1;
                    end
                end
                FN_PUSH_BACK:
                begin
                    if (full)
                        res_status = ST_FULL;
                    else
                    begin
                        for (int i = 0; i < CAPACITY; i++)
                            if (CNT_W'(i) == count_reg)
                                cells_next[i] = in_val;
                        count_next = count_reg + 1'b1;
                    end
                end
                FN_DELETE:
                begin
                    if (!in_range)
                        res_status = ST_RANGE;
                    else
                    begin
                        res_rval = DATA_W'(rd_data);
                        for (int i = 0; i < CAPACITY - 1; i++)
                            if (CMP_W'(i) >= pos_c)
                                cells_next[i] = cells_reg[i+1];
                        count_next = count_reg - 1'b1;
                    end
                end
                FN_READ:
                begin
                    if (!in_range)
                        res_status = ST_RANGE;
                    else
                        res_rval = DATA_W'(rd_data);
                end
                default:
                begin
                    res_status = ST_OK;
                end
            endcase
        end
    end

    // Response payload: loaded on a transfer of any request but a find, or
    // at the end of a find scan.
    always_comb
    begin
        out_load    = 1'b0;
        status_next = status_reg;
        fpos_next   = fpos_reg;
        rval_next   = rval_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        if (cmd.exec)
        begin
            idx_next = '0;
            if (op != FN_FIND)
            begin
                out_load    = 1'b1;
                status_next = res_status;
                fpos_next   = position;
                rval_next   = res_rval;
                len_next    = LEN_W'(count_next);
            end
        end
        else if (cmd.scan)
        begin
            if (sts.scan_done)
            begin
                out_load    = 1'b1;
                status_next = scan_end ? ST_NOT_FOUND : ST_OK;
                fpos_next   = match ? POS_W'(idx_reg) : pos_reg;
                rval_next   = '0;
                len_next    = LEN_W'(count_reg);
            end
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cells_reg <= cells_next;
        if (cmd.exec)
        begin
            value_reg <= in_val;
            pos_reg   <= position;
        end
        if (out_load)
        begin
            status_reg <= status_next;
            fpos_reg   <= fpos_next;
            rval_reg   <= rval_next;
            len_reg    <= len_next;
        end
    end

    assign status         = status_reg;
    assign found_position = fpos_reg;
    assign read_value     = rval_reg;
    assign length         = len_reg;

endmodule
